FILE: src/stro_pkg.sv
// ----------------------------------------------------------------------------
// stro_pkg: shared types and constants for the spiral tile reveal order block
// Register indices, field widths and the status bundle of the linear divider.
// ----------------------------------------------------------------------------
package stro_pkg;

  // Configuration register indices
  localparam logic [2:0] REG_REVEAL_MODE  = 3'd0;
  localparam logic [2:0] REG_WIDTH_TILES  = 3'd1;
  localparam logic [2:0] REG_HEIGHT_TILES = 3'd2;
  localparam logic [2:0] REG_LEFT_COLUMN  = 3'd3;
  localparam logic [2:0] REG_TOP_ROW      = 3'd4;
  localparam logic [2:0] REG_BASE_TILE    = 3'd5;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  // Image sizes: width register is 6 bits, height register is 5 bits.
  localparam int unsigned WidW   = 6;
  localparam int unsigned HgtW   = 5;
  // Linear index never exceeds 63 * 31, spiral step count never exceeds 63 * 63.
  localparam int unsigned LinW   = 11;
  localparam int unsigned StepW  = 12;
  // Signed spiral coordinates and directions.
  localparam int unsigned WalkW  = 7;
  localparam int unsigned DirW   = 2;
  localparam int unsigned ScrW   = 6;
  localparam int unsigned TileW  = 16;
  localparam int unsigned DivCntW = 4;

  // Result of re-deriving the linear row and column after a width change.
  typedef struct packed {
    logic            done;
    logic [LinW-1:0] quotient;
    logic [WidW-1:0] remainder;
  } div_res_t;

endpackage

FILE: src/spiral_tile_reveal_order.sv
// ----------------------------------------------------------------------------
// spiral_tile_reveal_order: tile reveal sequence for a tile-mapped screen
// Produces one tile placement per step, either as an outward square spiral
// from the image centre or in row-major order.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake             | Payload
//  ---------+-----------+-----------------------+------------------------------------
//  in       | input     | in_valid_i/in_stall_o | restart_i
//  out      | output    | out_valid_o/out_stall_i| shown_o, screen_column_o,
//           |           |                       | screen_row_o, tile_number_o, walk_done_o
//  cfg      | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// Each step transaction is completed at the edge of acceptance: the walk state
// is updated and the result register loaded there, so one step can be accepted
// every cycle while the downstream side keeps up and no division is running.
// A write to the width register starts a restoring division that re-derives the
// linear row and column; input transactions stall during it.
// Reset is asynchronous and active low; it restores the register defaults and
// the start of the walk. A stalled result holds the output register, and a new
// step is taken in the same cycle that the waiting result leaves.
// ----------------------------------------------------------------------------
module spiral_tile_reveal_order #(
  parameter int unsigned MAX_WIDE = 32,
  parameter int unsigned MAX_HIGH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // step channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          restart_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          shown_o,
  output logic [stro_pkg::ScrW-1:0]     screen_column_o,
  output logic [stro_pkg::ScrW-1:0]     screen_row_o,
  output logic [stro_pkg::TileW-1:0]    tile_number_o,
  output logic                          walk_done_o,
  // configuration channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [stro_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [stro_pkg::CfgDatW-1:0]  cfg_data_i
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                          mode_q;
  logic [stro_pkg::WidW-1:0]     width_q;
  logic [stro_pkg::HgtW-1:0]     height_q;
  logic [4:0]                    left_q;
  logic [4:0]                    top_q;
  logic [stro_pkg::TileW-1:0]    base_q;
  logic                          cfg_we;
  logic                          width_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign width_we    = cfg_we && (cfg_index_i == stro_pkg::REG_WIDTH_TILES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      width_q  <= stro_pkg::WidW'(32);
      height_q <= stro_pkg::HgtW'(24);
      left_q   <= '0;
      top_q    <= '0;
      base_q   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        stro_pkg::REG_REVEAL_MODE:  mode_q   <= cfg_data_i[0];
        stro_pkg::REG_WIDTH_TILES:  width_q  <= cfg_data_i[stro_pkg::WidW-1:0];
        stro_pkg::REG_HEIGHT_TILES: height_q <= cfg_data_i[stro_pkg::HgtW-1:0];
        stro_pkg::REG_LEFT_COLUMN:  left_q   <= cfg_data_i[4:0];
        stro_pkg::REG_TOP_ROW:      top_q    <= cfg_data_i[4:0];
        stro_pkg::REG_BASE_TILE:    base_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Effective image size, clamped to at least one tile and to the maxima
  // --------------------------------------------------------------------------
  logic [stro_pkg::WidW-1:0]  w;
  logic [stro_pkg::HgtW-1:0]  h;
  logic [stro_pkg::WidW-1:0]  side;
  logic [stro_pkg::StepW-1:0] total_s;
  logic [stro_pkg::LinW-1:0]  total_l;

  always_comb begin
    if (width_q == '0) begin
      w = stro_pkg::WidW'(1);
    end else if ({1'b0, width_q} > 7'(MAX_WIDE)) begin
      w = stro_pkg::WidW'(MAX_WIDE);
    end else begin
      w = width_q;
    end
    if (height_q == '0) begin
      h = stro_pkg::HgtW'(1);
    end else if ({2'b0, height_q} > 7'(MAX_HIGH)) begin
      h = stro_pkg::HgtW'(MAX_HIGH);
    end else begin
      h = height_q;
    end
  end

  assign side    = (w > {1'b0, h}) ? w : {1'b0, h};
  assign total_s = stro_pkg::StepW'(side * side);
  assign total_l = stro_pkg::LinW'(w * h);

  // --------------------------------------------------------------------------
  // Handshake and walk state
  // --------------------------------------------------------------------------
  logic accept;
  logic div_busy;
  logic out_valid_q;

  assign in_stall_o = div_busy || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  logic signed [stro_pkg::WalkW-1:0] walk_x_q, walk_x_d;
  logic signed [stro_pkg::WalkW-1:0] walk_y_q, walk_y_d;
  logic signed [stro_pkg::DirW-1:0]  dir_x_q, dir_x_d;
  logic signed [stro_pkg::DirW-1:0]  dir_y_q, dir_y_d;
  logic [stro_pkg::StepW-1:0]        step_q, step_d;
  logic [stro_pkg::LinW-1:0]         lin_q, lin_d;
  logic [stro_pkg::LinW-1:0]         lin_row_q, lin_row_d;
  logic [stro_pkg::WidW-1:0]         lin_col_q, lin_col_d;

  // The linear column and row are kept incrementally; a width change
  // re-derives them from the linear index by division.
  stro_pkg::div_res_t div_res;

  stro_lin_div u_lin_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (width_we),
    .dividend_i (lin_q),
    .divisor_i  (w),
    .busy_o     (div_busy),
    .res_o      (div_res)
  );

  // --------------------------------------------------------------------------
  // One step of the walk
  // --------------------------------------------------------------------------
  logic signed [stro_pkg::WalkW-1:0] cur_x, cur_y;
  logic signed [stro_pkg::DirW-1:0]  cur_dx, cur_dy;
  logic [stro_pkg::StepW-1:0]        cur_step;
  logic [stro_pkg::LinW-1:0]         cur_lin, cur_row;
  logic [stro_pkg::WidW-1:0]         cur_col;

  logic signed [7:0] xe, ye, x_off, y_off, cx, cy;
  logic              in_win, turn;
  logic [stro_pkg::WidW:0] col_inc;

  logic                       shown_d, done_d;
  logic [stro_pkg::ScrW-1:0]  col_d, row_d;
  logic [stro_pkg::TileW-1:0] tile_d;
  logic [stro_pkg::ScrW-1:0]  pos_col, pos_row;
  logic [stro_pkg::TileW-1:0] pos_tile;

  always_comb begin
    if (restart_i) begin
      cur_x    = '0;
      cur_y    = '0;
      cur_dx   = '0;
      cur_dy   = -stro_pkg::DirW'(1);
      cur_step = '0;
      cur_lin  = '0;
      cur_row  = '0;
      cur_col  = '0;
    end else begin
      cur_x    = walk_x_q;
      cur_y    = walk_y_q;
      cur_dx   = dir_x_q;
      cur_dy   = dir_y_q;
      cur_step = step_q;
      cur_lin  = lin_q;
      cur_row  = lin_row_q;
      cur_col  = lin_col_q;
    end
  end

  assign xe    = 8'(cur_x);
  assign ye    = 8'(cur_y);
  assign x_off = {3'b000, w[stro_pkg::WidW-1:1]};
  assign y_off = {4'b0000, h[stro_pkg::HgtW-1:1]};
  assign cx    = xe + x_off;
  assign cy    = ye + y_off;
  // Offset must lie inside the half-size window and inside the image itself.
  assign in_win = (xe >= -x_off) && (xe <= x_off) && (ye >= -y_off) && (ye <= y_off)
               && (cx >= 8'sd0) && (cy >= 8'sd0)
               && (cx < $signed({2'b00, w})) && (cy < $signed({3'b000, h}));
  // Corners of the square spiral.
  assign turn = (xe == ye)
             || ((xe < 8'sd0) && (xe == -ye))
             || ((xe > 8'sd0) && (xe == 8'sd1 - ye));
  assign col_inc = {1'b0, cur_col} + 1'b1;

  always_comb begin
    walk_x_d  = cur_x;
    walk_y_d  = cur_y;
    dir_x_d   = cur_dx;
    dir_y_d   = cur_dy;
    step_d    = cur_step;
    lin_d     = cur_lin;
    lin_row_d = cur_row;
    lin_col_d = cur_col;
    shown_d   = 1'b0;
    done_d    = 1'b0;
    pos_col   = '0;
    pos_row   = '0;
    pos_tile  = '0;

    if (mode_q) begin
      if (cur_lin >= total_l) begin
        done_d = 1'b1;
      end else begin
        shown_d  = 1'b1;
        pos_col  = cur_col;
        pos_row  = cur_row[stro_pkg::ScrW-1:0];
        pos_tile = {8'h00, 8'(cur_lin + stro_pkg::LinW'(base_q[7:0]))};
        lin_d    = cur_lin + 1'b1;
        if (col_inc == {1'b0, w}) begin
          lin_col_d = '0;
          lin_row_d = cur_row + 1'b1;
        end else begin
          lin_col_d = col_inc[stro_pkg::WidW-1:0];
        end
        done_d = lin_d >= total_l;
      end
    end else begin
      if (cur_step >= total_s) begin
        done_d = 1'b1;
      end else begin
        if (in_win) begin
          shown_d  = 1'b1;
          pos_col  = cx[stro_pkg::ScrW-1:0];
          pos_row  = cy[stro_pkg::ScrW-1:0];
          pos_tile = stro_pkg::TileW'(cy[stro_pkg::HgtW-1:0] * w)
                   + stro_pkg::TileW'(cx[stro_pkg::WidW-1:0]) + base_q;
        end
        if (turn) begin
          dir_x_d = -cur_dy;
          dir_y_d = cur_dx;
        end
        walk_x_d = cur_x + stro_pkg::WalkW'(dir_x_d);
        walk_y_d = cur_y + stro_pkg::WalkW'(dir_y_d);
        step_d   = cur_step + 1'b1;
        done_d   = step_d >= total_s;
      end
    end

    if (shown_d) begin
      col_d  = pos_col + {1'b0, left_q};
      row_d  = pos_row + {1'b0, top_q};
      tile_d = pos_tile;
    end else begin
      col_d  = '0;
      row_d  = '0;
      tile_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_x_q  <= '0;
      walk_y_q  <= '0;
      dir_x_q   <= '0;
      dir_y_q   <= -stro_pkg::DirW'(1);
      step_q    <= '0;
      lin_q     <= '0;
      lin_row_q <= '0;
      lin_col_q <= '0;
    end else if (accept) begin
      walk_x_q  <= walk_x_d;
      walk_y_q  <= walk_y_d;
      dir_x_q   <= dir_x_d;
      dir_y_q   <= dir_y_d;
      step_q    <= step_d;
      lin_q     <= lin_d;
      lin_row_q <= lin_row_d;
      lin_col_q <= lin_col_d;
    end else if (div_res.done) begin
      lin_row_q <= div_res.quotient;
      lin_col_q <= div_res.remainder;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic                       shown_q, done_q;
  logic [stro_pkg::ScrW-1:0]  col_q, row_q;
  logic [stro_pkg::TileW-1:0] tile_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      shown_q <= shown_d;
      col_q   <= col_d;
      row_q   <= row_d;
      tile_q  <= tile_d;
      done_q  <= done_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign shown_o         = shown_q;
  assign screen_column_o = col_q;
  assign screen_row_o    = row_q;
  assign tile_number_o   = tile_q;
  assign walk_done_o     = done_q;

endmodule

FILE: src/stro_lin_div.sv
// ----------------------------------------------------------------------------
// stro_lin_div: restoring divider for the linear walk position
// Splits the linear tile index into row and column, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module stro_lin_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [stro_pkg::LinW-1:0] dividend_i,
  input  logic [stro_pkg::WidW-1:0] divisor_i,
  output logic                     busy_o,
  output stro_pkg::div_res_t       res_o
);

  logic                           busy_q;
  logic [stro_pkg::DivCntW-1:0]   cnt_q;
  logic [stro_pkg::LinW-1:0]      quo_q;
  logic [stro_pkg::WidW-1:0]      rem_q;
  logic [stro_pkg::WidW:0]        rem_sh;
  logic                           ge;
  logic [stro_pkg::WidW-1:0]      rem_n;
  logic [stro_pkg::LinW-1:0]      quo_n;
  logic                           last;

  assign rem_sh = {rem_q, quo_q[stro_pkg::LinW-1]};
  assign ge     = rem_sh >= {1'b0, divisor_i};
  assign rem_n  = ge ? stro_pkg::WidW'(rem_sh - {1'b0, divisor_i})
                     : rem_sh[stro_pkg::WidW-1:0];
  assign quo_n  = {quo_q[stro_pkg::LinW-2:0], ge};
  assign last   = cnt_q == stro_pkg::DivCntW'(stro_pkg::LinW - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      busy_q <= !last;
      cnt_q  <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= quo_n;
      rem_q <= rem_n;
    end
  end

  assign busy_o          = busy_q;
  assign res_o.done      = busy_q && last && !start_i;
  assign res_o.quotient  = quo_n;
  assign res_o.remainder = rem_n;

endmodule
